// ===== design/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the link traffic statistics engine.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int NodesDefault = 16;
	localparam int NodeW = 4;
	localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
	localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] StatOk = 2'd0;
	localparam logic [1:0] StatBadStart = 2'd1;
	localparam logic [1:0] StatIgnored = 2'd2;

	localparam logic [2:0] EvCreated = 3'd0;
	localparam logic [2:0] EvArrived = 3'd1;
	localparam logic [2:0] EvLeft = 3'd2;
	localparam logic [2:0] EvDelivered = 3'd3;
	localparam logic [2:0] EvLost = 3'd4;

	localparam int SumW = 3;
	localparam logic [SumW-1:0] SumQueue = 3'd0;
	localparam logic [SumW-1:0] SumTransmit = 3'd1;
	localparam logic [SumW-1:0] SumDelay = 3'd2;
	localparam logic [SumW-1:0] SumNone = 3'd3;

	typedef struct packed {
		logic command;
		logic [2:0] event_code;
		logic [31:0] event_time;
		logic [NodeW-1:0] src_node;
		logic [NodeW-1:0] dst_node;
		logic [NodeW-1:0] position;
		logic first_of_packet;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] sent_count;
		logic [31:0] handled_count;
		logic [31:0] received_count;
		logic [31:0] lost_count;
		logic [47:0] queue_time_sum;
		logic [47:0] transmit_time_sum;
		logic [47:0] delay_time_sum;
	} out_word_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic is_read;
		logic [1:0] status;
		logic [NodeW-1:0] rd_row;
		logic [NodeW-1:0] rd_col;
		logic sent_en;
		logic hand_en;
		logic recv_en;
		logic lost_en;
		logic [NodeW-1:0] sh_row;
		logic [NodeW-1:0] sh_col;
		logic [NodeW-1:0] hb_row;
		logic [NodeW-1:0] hb_col;
		logic [NodeW-1:0] rv_row;
		logic [NodeW-1:0] rv_col;
		logic [NodeW-1:0] lo_row;
		logic [NodeW-1:0] lo_col;
		logic [SumW-1:0] sum_sel;
		logic [NodeW-1:0] sm_row;
		logic [NodeW-1:0] sm_col;
		logic [31:0] delta;
		logic [SumW-1:0] sum2_sel;
		logic [NodeW-1:0] s2_row;
		logic [NodeW-1:0] s2_col;
		logic [31:0] delta2;
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_WRITE
	} bk_state_t;

endpackage

// ===== design/link_traffic_stats_engine.sv =====
// ----------------------------------------------------------------------------
// link_traffic_stats_engine
// Per-link packet counters and delay sums built from packet trace words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_word) takes trace events and read
// commands in trace order. The front end tracks the open packet and turns
// each word into a table operation; a two-entry queue feeds the back end.
// The back end reads all tables together and, for an update, writes them
// in the next cycle, then posts one result word per input word on
// out_valid/out_ready/out_word. A trace event returns its status with
// zeroed fields; a read returns the link's counters and sums.
// The back end takes a new word only after posting the result of the last.
// A word passes the queue, READ and, for an update, WRITE before out_valid.
// Reset clears the packet state and starts a clearing pass that zeroes one
// table entry per cycle, NODES*NODES entries (256 by default); the queue
// takes two words meanwhile and in_ready then drops until the pass ends.
// When the receiver stalls, the result register holds and the queue
// absorbs up to two more words before in_ready drops.
// ----------------------------------------------------------------------------
module link_traffic_stats_engine import lts_pkg::*; #(
	parameter int NODES = NodesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output out_word_t out_word
);

	logic f_valid, f_ready, b_valid, b_ready;
	op_t f_op, b_op;

	lts_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	lts_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_op(f_op),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_op(b_op)
	);

	lts_back #(.NODES(NODES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(b_valid), .op_ready(b_ready), .op(b_op),
		.res_valid(out_valid), .res_ready(out_ready), .res(out_word)
	);

	property p_ok_fields_zero;
		@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != StatOk |-> out_word.sent_count == 32'd0;
	endproperty
	a_ok_fields_zero: assert property (p_ok_fields_zero) else $error("nonzero count on bad status");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word);
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

	property p_status_range;
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status != 2'd3;
	endproperty
	a_status_range: assert property (p_status_range) else $error("bad status code");

endmodule

// ===== design/lts_front.sv =====
// ----------------------------------------------------------------------------
// lts_front
// Tracks the open packet and turns each word into a table operation.
// ----------------------------------------------------------------------------
module lts_front import lts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_word,
	output logic op_valid,
	input  logic op_ready,
	output op_t op
);

	logic [31:0] creation_time_q, prev_time_q;
	logic [NodeW-1:0] packet_source_q, packet_dest_q, prev_position_q, before_prev_position_q;
	logic [2:0] prev_code_q;
	logic packet_valid_q;
	logic take, upd;
	logic [31:0] d_prev, d_create;

	assign in_ready = op_ready;
	assign op_valid = in_valid;
	assign take = in_valid && op_ready;

	always_comb begin
		d_prev = (in_word.event_time > prev_time_q) ? in_word.event_time - prev_time_q : 32'd0;
		d_create = (in_word.event_time > creation_time_q) ?
			in_word.event_time - creation_time_q : 32'd0;
	end

	always_comb begin
		op = '0;
		op.sum_sel = SumNone;
		op.sum2_sel = SumNone;
		op.rd_row = in_word.src_node;
		op.rd_col = in_word.dst_node;
		op.status = StatOk;
		upd = 1'b0;
		if (in_word.command) begin
			op.is_read = 1'b1;
		end else if (in_word.event_code > EvLost) begin
			op.status = StatIgnored;
		end else if (in_word.first_of_packet && in_word.event_code != EvCreated) begin
			op.status = StatBadStart;
		end else if (!in_word.first_of_packet && !packet_valid_q) begin
			op.status = StatIgnored;
		end else begin
			upd = 1'b1;
			if (!in_word.first_of_packet) begin
				if ((prev_code_q == EvCreated || prev_code_q == EvArrived) &&
						in_word.event_code == EvLeft) begin
					op.sum_sel = SumQueue;
					op.sm_row = prev_position_q;
					op.sm_col = in_word.position;
					op.delta = d_prev;
				end
				if (prev_code_q == EvLeft && in_word.event_code == EvArrived) begin
					op.sum_sel = SumTransmit;
					op.sm_row = before_prev_position_q;
					op.sm_col = in_word.position;
					op.delta = d_prev;
				end
			end
			op.sh_row = in_word.src_node;
			op.sh_col = in_word.dst_node;
			op.hb_row = in_word.position;
			op.hb_col = in_word.dst_node;
			op.rv_row = in_word.dst_node;
			op.rv_col = in_word.src_node;
			op.lo_row = in_word.position;
			op.lo_col = in_word.dst_node;
			case (in_word.event_code)
				EvCreated: begin
					op.sent_en = 1'b1;
					op.hand_en = 1'b1;
					op.hb_row = in_word.src_node;
				end
				EvArrived: op.hand_en = in_word.position != in_word.dst_node;
				EvDelivered: begin
					op.recv_en = 1'b1;
					op.sum2_sel = SumDelay;
					op.s2_row = in_word.first_of_packet ? in_word.src_node : packet_source_q;
					op.s2_col = in_word.first_of_packet ? in_word.dst_node : packet_dest_q;
					op.delta2 = in_word.first_of_packet ? 32'd0 : d_create;
				end
				EvLost: op.lost_en = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			creation_time_q <= '0;
			prev_time_q <= '0;
			packet_source_q <= '0;
			packet_dest_q <= '0;
			prev_position_q <= '0;
			before_prev_position_q <= '0;
			prev_code_q <= '0;
			packet_valid_q <= 1'b0;
		end else if (take && !in_word.command) begin
			if (op.status == StatBadStart) begin
				packet_valid_q <= 1'b0;
			end else if (upd) begin
				if (in_word.first_of_packet) begin
					packet_valid_q <= 1'b1;
					creation_time_q <= in_word.event_time;
					packet_source_q <= in_word.src_node;
					packet_dest_q <= in_word.dst_node;
					before_prev_position_q <= in_word.position;
				end else begin
					before_prev_position_q <= prev_position_q;
				end
				prev_position_q <= in_word.position;
				prev_code_q <= in_word.event_code;
				prev_time_q <= in_word.event_time;
			end
		end
	end

endmodule

// ===== design/lts_queue.sv =====
// ----------------------------------------------------------------------------
// lts_queue
// Two-entry queue between classification and table update.
// ----------------------------------------------------------------------------
module lts_queue import lts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  op_t wr_op,
	output logic rd_valid,
	input  logic rd_ready,
	output op_t rd_op
);

	op_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_op = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/lts_back.sv =====
// ----------------------------------------------------------------------------
// lts_back
// Holds the link tables and applies one operation per read and write pass.
// ----------------------------------------------------------------------------
module lts_back import lts_pkg::*; #(
	parameter int NODES = NodesDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t op,
	output logic res_valid,
	input  logic res_ready,
	output out_word_t res
);

	localparam int Cells = NODES * NODES;
	localparam int IdxW = (Cells > 1) ? $clog2(Cells) : 1;

	logic [31:0] sent_mem [Cells];
	logic [31:0] hand_mem [Cells];
	logic [31:0] recv_mem [Cells];
	logic [31:0] lost_mem [Cells];
	logic [47:0] queue_mem [Cells];
	logic [47:0] xmit_mem [Cells];
	logic [47:0] delay_mem [Cells];

	bk_state_t state_q, state_d;
	op_t op_q;
	logic [IdxW-1:0] clr_q;
	logic [IdxW-1:0] sh_a, hb_a, rv_a, lo_a, sm_a, s2_a;
	logic [31:0] sent_rd, hand_rd, recv_rd, lost_rd;
	logic [47:0] queue_rd, xmit_rd, delay_rd, s1_rd, s2_rd;
	logic res_valid_q, res_valid_d;
	out_word_t res_q, res_d;
	logic out_free, start, done;

	function automatic logic in_rng(input logic [NodeW-1:0] r, input logic [NodeW-1:0] c);
		return (int'(r) < NODES) && (int'(c) < NODES);
	endfunction

	function automatic logic [IdxW-1:0] idx(input logic [NodeW-1:0] r, input logic [NodeW-1:0] c);
		logic [2*NodeW+6:0] p;
		p = (2*NodeW+7)'(r) * (2*NodeW+7)'(NODES) + (2*NodeW+7)'(c);
		return p[IdxW-1:0];
	endfunction

	function automatic logic [31:0] inc32(input logic [31:0] v);
		return (v == Max32) ? v : v + 32'd1;
	endfunction

	function automatic logic [47:0] add48(input logic [47:0] v, input logic [31:0] d);
		logic [48:0] s;
		s = {1'b0, v} + 49'(d);
		return s[48] ? Max48 : s[47:0];
	endfunction

	assign out_free = !res_valid_q || res_ready;
	assign start = state_q == BK_IDLE && op_valid;
	assign done = (state_q == BK_READ || state_q == BK_WRITE) && state_d == BK_IDLE;
	assign op_ready = start;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_q == IdxW'(Cells - 1)) state_d = BK_IDLE;
			BK_IDLE: if (op_valid) state_d = BK_READ;
			BK_READ: if (op_q.is_read || op_q.status != StatOk) begin
				if (out_free) state_d = BK_IDLE;
			end else begin
				state_d = BK_WRITE;
			end
			BK_WRITE: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		sh_a = idx(op.is_read ? op.rd_row : op.sh_row, op.is_read ? op.rd_col : op.sh_col);
		hb_a = idx(op.is_read ? op.rd_row : op.hb_row, op.is_read ? op.rd_col : op.hb_col);
		rv_a = idx(op.is_read ? op.rd_row : op.rv_row, op.is_read ? op.rd_col : op.rv_col);
		lo_a = idx(op.is_read ? op.rd_row : op.lo_row, op.is_read ? op.rd_col : op.lo_col);
		sm_a = idx(op.is_read ? op.rd_row : op.sm_row, op.is_read ? op.rd_col : op.sm_col);
		s2_a = idx(op.is_read ? op.rd_row : op.s2_row, op.is_read ? op.rd_col : op.s2_col);
	end

	// registered reads; address from incoming op
	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			sent_rd <= sent_mem[sh_a];
			hand_rd <= hand_mem[hb_a];
			recv_rd <= recv_mem[rv_a];
			lost_rd <= lost_mem[lo_a];
			queue_rd <= queue_mem[sm_a];
			xmit_rd <= xmit_mem[sm_a];
			delay_rd <= delay_mem[s2_a];
		end
	end

	assign s1_rd = (op_q.sum_sel == SumQueue) ? queue_rd : xmit_rd;
	assign s2_rd = delay_rd;

	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR) begin
			sent_mem[clr_q] <= '0;
			hand_mem[clr_q] <= '0;
			recv_mem[clr_q] <= '0;
			lost_mem[clr_q] <= '0;
			queue_mem[clr_q] <= '0;
			xmit_mem[clr_q] <= '0;
			delay_mem[clr_q] <= '0;
		end else if (state_q == BK_READ && !op_q.is_read && op_q.status == StatOk) begin
			if (op_q.sent_en && in_rng(op_q.sh_row, op_q.sh_col))
				sent_mem[idx(op_q.sh_row, op_q.sh_col)] <= inc32(sent_rd);
			if (op_q.hand_en && in_rng(op_q.hb_row, op_q.hb_col))
				hand_mem[idx(op_q.hb_row, op_q.hb_col)] <= inc32(hand_rd);
			if (op_q.recv_en && in_rng(op_q.rv_row, op_q.rv_col))
				recv_mem[idx(op_q.rv_row, op_q.rv_col)] <= inc32(recv_rd);
			if (op_q.lost_en && in_rng(op_q.lo_row, op_q.lo_col))
				lost_mem[idx(op_q.lo_row, op_q.lo_col)] <= inc32(lost_rd);
			if (op_q.sum_sel == SumQueue && in_rng(op_q.sm_row, op_q.sm_col))
				queue_mem[idx(op_q.sm_row, op_q.sm_col)] <= add48(s1_rd, op_q.delta);
			if (op_q.sum_sel == SumTransmit && in_rng(op_q.sm_row, op_q.sm_col))
				xmit_mem[idx(op_q.sm_row, op_q.sm_col)] <= add48(s1_rd, op_q.delta);
			if (op_q.sum2_sel == SumDelay && in_rng(op_q.s2_row, op_q.s2_col))
				delay_mem[idx(op_q.s2_row, op_q.s2_col)] <= add48(s2_rd, op_q.delta2);
		end
	end

	always_comb begin
		if (done)
			res_valid_d = 1'b1;
		else if (res_ready)
			res_valid_d = 1'b0;
		else
			res_valid_d = res_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + IdxW'(1);
			res_valid_q <= res_valid_d;
		end
	end

	always_comb begin
		res_d = '0;
		res_d.status = op_q.status;
		if (op_q.is_read) begin
			if (in_rng(op_q.rd_row, op_q.rd_col)) begin
				res_d.sent_count = sent_rd;
				res_d.handled_count = hand_rd;
				res_d.received_count = recv_rd;
				res_d.lost_count = lost_rd;
				res_d.queue_time_sum = queue_rd;
				res_d.transmit_time_sum = xmit_rd;
				res_d.delay_time_sum = delay_rd;
			end else begin
				res_d.status = StatIgnored;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== bench/link_stats_checker.sv =====
// ----------------------------------------------------------------------------
// link_stats_checker
// Watches both channels of the engine, tracks per-link statistics on its own
// and compares every result word against the predicted one, field by field.
// ----------------------------------------------------------------------------
module link_stats_checker import lts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_word_t in_word,
	input  logic out_valid,
	input  logic out_ready,
	input  out_word_t out_word,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] sent_tab [256];
	logic [31:0] hand_tab [256];
	logic [31:0] recv_tab [256];
	logic [31:0] lost_tab [256];
	logic [47:0] queue_tab [256];
	logic [47:0] xmit_tab [256];
	logic [47:0] delay_tab [256];
	logic [31:0] born_time;
	logic [3:0] pkt_src, pkt_dst, last_pos, older_pos;
	logic [2:0] last_code;
	logic [31:0] last_time;
	logic pkt_open;
	out_word_t expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [31:0] bump32(logic [31:0] v);
		return (v == Max32) ? v : v + 32'd1;
	endfunction

	function automatic logic [47:0] add_clamped(logic [47:0] sum, logic [31:0] later,
			logic [31:0] earlier);
		logic [48:0] s;
		s = {1'b0, sum} + ((later > earlier) ? later - earlier : 32'd0);
		return s[48] ? Max48 : s[47:0];
	endfunction

	task automatic predict_link_result(input in_word_t w, output out_word_t r);
		logic [7:0] ix;
		r = '0;
		if (w.command) begin
			ix = {w.src_node, w.dst_node};
			r.sent_count = sent_tab[ix];
			r.handled_count = hand_tab[ix];
			r.received_count = recv_tab[ix];
			r.lost_count = lost_tab[ix];
			r.queue_time_sum = queue_tab[ix];
			r.transmit_time_sum = xmit_tab[ix];
			r.delay_time_sum = delay_tab[ix];
			r.status = StatOk;
			return;
		end
		if (w.event_code > EvLost) begin
			r.status = StatIgnored;
			return;
		end
		if (w.first_of_packet) begin
			if (w.event_code != EvCreated) begin
				pkt_open = 1'b0;
				r.status = StatBadStart;
				return;
			end
			pkt_open = 1'b1;
			born_time = w.event_time;
			pkt_src = w.src_node;
			pkt_dst = w.dst_node;
			last_pos = w.position;
			older_pos = w.position;
		end else begin
			if (!pkt_open) begin
				r.status = StatIgnored;
				return;
			end
			if ((last_code == EvCreated || last_code == EvArrived) && w.event_code == EvLeft) begin
				ix = {last_pos, w.position};
				queue_tab[ix] = add_clamped(queue_tab[ix], w.event_time, last_time);
			end
			if (last_code == EvLeft && w.event_code == EvArrived) begin
				ix = {older_pos, w.position};
				xmit_tab[ix] = add_clamped(xmit_tab[ix], w.event_time, last_time);
			end
		end
		case (w.event_code)
			EvCreated: begin
				ix = {w.src_node, w.dst_node};
				sent_tab[ix] = bump32(sent_tab[ix]);
				hand_tab[ix] = bump32(hand_tab[ix]);
			end
			EvArrived: begin
				ix = {w.position, w.dst_node};
				if (w.position != w.dst_node)
					hand_tab[ix] = bump32(hand_tab[ix]);
			end
			EvDelivered: begin
				ix = {pkt_src, pkt_dst};
				delay_tab[ix] = add_clamped(delay_tab[ix], w.event_time, born_time);
				ix = {w.dst_node, w.src_node};
				recv_tab[ix] = bump32(recv_tab[ix]);
			end
			EvLost: begin
				ix = {w.position, w.dst_node};
				lost_tab[ix] = bump32(lost_tab[ix]);
			end
			default: ;
		endcase
		older_pos = last_pos;
		last_pos = w.position;
		last_code = w.event_code;
		last_time = w.event_time;
		r.status = StatOk;
	endtask

	task automatic compare_word(input out_word_t e, input out_word_t a);
		if (a.status !== e.status)
			$error("status expected %0d got %0d", e.status, a.status);
		if (a.sent_count !== e.sent_count)
			$error("sent_count expected %0h got %0h", e.sent_count, a.sent_count);
		if (a.handled_count !== e.handled_count)
			$error("handled_count expected %0h got %0h", e.handled_count, a.handled_count);
		if (a.received_count !== e.received_count)
			$error("received_count expected %0h got %0h", e.received_count, a.received_count);
		if (a.lost_count !== e.lost_count)
			$error("lost_count expected %0h got %0h", e.lost_count, a.lost_count);
		if (a.queue_time_sum !== e.queue_time_sum)
			$error("queue_time_sum expected %0h got %0h", e.queue_time_sum, a.queue_time_sum);
		if (a.transmit_time_sum !== e.transmit_time_sum)
			$error("transmit_time_sum expected %0h got %0h", e.transmit_time_sum,
				a.transmit_time_sum);
		if (a.delay_time_sum !== e.delay_time_sum)
			$error("delay_time_sum expected %0h got %0h", e.delay_time_sum, a.delay_time_sum);
		if (a !== e)
			errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t r;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) begin
				sent_tab[i] = '0;
				hand_tab[i] = '0;
				recv_tab[i] = '0;
				lost_tab[i] = '0;
				queue_tab[i] = '0;
				xmit_tab[i] = '0;
				delay_tab[i] = '0;
			end
			born_time = '0;
			pkt_src = '0;
			pkt_dst = '0;
			last_pos = '0;
			older_pos = '0;
			last_code = '0;
			last_time = '0;
			pkt_open = 1'b0;
			errors = 0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no expectation waiting");
					errors++;
				end else begin
					compare_word(expected_results.pop_front(), out_word);
				end
			end
			if (in_valid && in_ready) begin
				predict_link_result(in_word, r);
				expected_results.push_back(r);
			end
		end
	end
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives trace events and link reads into the statistics engine: a directed
// opening over the special cases, then random packet traces mixed with noise
// and reads, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb import lts_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 2000;

	logic clk, arst_n, in_valid, in_ready, out_valid;
	logic out_ready = 1'b0;
	in_word_t in_word;
	out_word_t out_word;
	int errors, pending, burst_left, words_sent;
	int idle_cycles = 0;

	link_traffic_stats_engine dut (.*);
	link_stats_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: phases of always ready, random stalls and long stalls
	int stall_phase = 0, phase_left = 0;
	always @(posedge clk) begin
		if (phase_left == 0) begin
			stall_phase <= $urandom_range(0, 2);
			phase_left <= $urandom_range(10, 60);
		end else begin
			phase_left <= phase_left - 1;
		end
		case (stall_phase)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	function automatic in_word_t make_word(logic cmd, logic [2:0] code, logic [31:0] t,
			logic [3:0] src, logic [3:0] dst, logic [3:0] pos, logic first);
		in_word_t w;
		w.command = cmd;
		w.event_code = code;
		w.event_time = t;
		w.src_node = src;
		w.dst_node = dst;
		w.position = pos;
		w.first_of_packet = first;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		burst_left--;
		words_sent++;
	endtask

	function automatic logic [3:0] pick_node();
		return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [31:0] step_time(logic [31:0] t);
		if ($urandom_range(0, 9) == 0)
			return t - $urandom_range(0, 5000);
		return t + $urandom_range(0, 1 << $urandom_range(4, 20));
	endfunction

	task automatic send_read();
		in_word_t w;
		w = in_word_t'({$urandom, $urandom});
		w.command = 1'b1;
		w.src_node = pick_node();
		w.dst_node = pick_node();
		send_word(w);
	endtask

	task automatic send_packet();
		logic [3:0] src, dst, cur, nxt;
		logic [31:0] t;
		int hops;
		src = pick_node();
		dst = pick_node();
		cur = src;
		t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535) : $urandom;
		send_word(make_word(1'b0, EvCreated, t, src, dst, src, 1'b1));
		hops = $urandom_range(1, 4);
		for (int h = 0; h < hops; h++) begin
			nxt = (h == hops - 1) ? dst : pick_node();
			t = step_time(t);
			send_word(make_word(1'b0, EvLeft, t, src, dst, cur, 1'b0));
			if ($urandom_range(0, 7) == 0) begin
				send_word(make_word(1'b0, EvLost, step_time(t), src, dst, cur, 1'b0));
				return;
			end
			t = step_time(t);
			send_word(make_word(1'b0, EvArrived, t, src, dst, nxt, 1'b0));
			if ($urandom_range(0, 7) == 0)
				send_word(make_word(1'b0, EvArrived, step_time(t), src, dst, nxt, 1'b0));
			cur = nxt;
		end
		send_word(make_word(1'b0, EvDelivered, step_time(t), src, dst, dst, 1'b0));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		burst_left = 0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd0, 4'd0, 4'd0, 1'b0));
		send_word(make_word(1'b0, EvArrived, 32'h10, 4'd1, 4'd2, 4'd1, 1'b0));
		send_word(make_word(1'b0, EvCreated, 32'h0, 4'd1, 4'd2, 4'd1, 1'b1));
		send_word(make_word(1'b0, EvLeft, 32'h150, 4'd1, 4'd2, 4'd1, 1'b0));
		send_word(make_word(1'b0, EvArrived, 32'h300, 4'd1, 4'd2, 4'd3, 1'b0));
		send_word(make_word(1'b0, EvLeft, 32'h200, 4'd1, 4'd2, 4'd3, 1'b0));
		send_word(make_word(1'b0, EvArrived, 32'h900, 4'd1, 4'd2, 4'd2, 1'b0));
		send_word(make_word(1'b0, EvDelivered, 32'hFFFF_FFFF, 4'd1, 4'd2, 4'd2, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd1, 4'd2, 4'd0, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd2, 4'd1, 4'd0, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd1, 4'd3, 4'd0, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd3, 4'd2, 4'd0, 1'b0));
		send_word(make_word(1'b0, EvArrived, 32'h5, 4'd4, 4'd5, 4'd4, 1'b1));
		send_word(make_word(1'b0, EvLeft, 32'h6, 4'd4, 4'd5, 4'd4, 1'b0));
		send_word(make_word(1'b0, 3'd5, 32'h7, 4'd4, 4'd5, 4'd4, 1'b1));
		send_word(make_word(1'b0, 3'd6, 32'h7, 4'd4, 4'd5, 4'd4, 1'b0));
		send_word(make_word(1'b0, 3'd7, 32'hFFFF_FFFF, 4'd15, 4'd15, 4'd15, 1'b0));
		send_word(make_word(1'b0, EvCreated, 32'hFFFF_FFFF, 4'd15, 4'd15, 4'd15, 1'b1));
		send_word(make_word(1'b0, EvCreated, 32'h0, 4'd15, 4'd14, 4'd15, 1'b0));
		send_word(make_word(1'b0, EvLost, 32'h0, 4'd15, 4'd14, 4'd15, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd15, 4'd15, 4'd0, 1'b0));
		send_word(make_word(1'b1, EvCreated, 32'h0, 4'd15, 4'd14, 4'd0, 1'b0));

		while (words_sent < 530) begin
			case ($urandom_range(0, 19))
				0, 1, 2: send_read();
				3, 4: send_word(in_word_t'({$urandom, $urandom}));
				default: send_packet();
			endcase
		end
		for (int r = 0; r < 8; r++)
			send_read();
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
